// ===== rtl/ste_pkg.sv =====
// Shared types and constants for the sprite tile expander.
// No dependencies; used by every module under rtl/.
`default_nettype none

package ste_pkg;

   // Screen positions wrap at 9 bits
   localparam int unsigned POS_W = 9;

   // Mirror points used when the whole screen is flipped
   localparam logic [POS_W-1:0] MIRROR_X  = 9'd368;
   localparam logic [POS_W-1:0] MIRROR_Y  = 9'd240;
   // One tile is 16 pixels on each axis
   localparam logic [POS_W-1:0] TILE_STEP = 9'd16;

   // Request kinds
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   // Configuration register indexes
   localparam int unsigned CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_FLIP_SCREEN     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_X_SHIFT         = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PER_SPRITE_FLIP = 2'd2;
   localparam int unsigned CSR_DATA_W = 7;

   typedef struct packed {
      logic       flip_screen;
      logic [6:0] x_shift;
      logic       per_sprite_flip;
   } cfg_type;

   typedef struct packed {
      logic        req_type;
      logic [15:0] attr_word;
      logic [15:0] size_word;
      logic [15:0] first_code;
      logic [15:0] x_word;
      logic [15:0] y_word;
      logic [15:0] color_word;
      logic [1:0]  pass_priority;
   } req_beat_type;

   // Sprite walk state; flips and directions hold x in bit 0, y in bit 1
   typedef struct packed {
      logic             pending;
      logic [15:0]      next_code;
      logic [15:0]      held_color;
      logic [1:0]       held_flips;
      logic [POS_W-1:0] cur_x;
      logic [POS_W-1:0] cur_y;
      logic [POS_W-1:0] row_start_x;
      logic [3:0]       cols_left;
      logic [3:0]       row_width;
      logic [3:0]       rows_left;
      logic [1:0]       step_dirs;
   } sprite_state_type;

endpackage

`default_nettype wire

// ===== rtl/ste_load_setup.sv =====
// Load decode: checks enable and priority of a sprite entry and builds
// its starting walk state. Depends on ste_pkg.
`default_nettype none

module ste_load_setup (
   input  var ste_pkg::req_beat_type     beat,
   input  var ste_pkg::cfg_type          cfg,
   output var ste_pkg::sprite_state_type state_o,
   output logic                          take_o
);

   logic [3:0]               width_m1;
   logic [3:0]               height_m1;
   logic                     fs;
   logic                     fx;
   logic                     fy;
   logic [ste_pkg::POS_W-1:0] sx_shift;
   logic [ste_pkg::POS_W-1:0] sx_base;
   logic [ste_pkg::POS_W-1:0] sy_base;
   logic [ste_pkg::POS_W-1:0] x_span;
   logic [ste_pkg::POS_W-1:0] y_span;
   logic [ste_pkg::POS_W-1:0] sx_start;
   logic [ste_pkg::POS_W-1:0] sy_start;

   // Entry is used only when enabled and in this pass's priority
   assign take_o = beat.attr_word[0] && (beat.attr_word[7:6] == beat.pass_priority);

   assign width_m1  = beat.size_word[3:0];
   assign height_m1 = beat.size_word[7:4];
   assign fs        = cfg.flip_screen;

   // Shifted and possibly mirrored origin
   assign sx_shift = beat.x_word[ste_pkg::POS_W-1:0] + {2'b00, cfg.x_shift};
   assign sx_base  = fs ? (ste_pkg::MIRROR_X - sx_shift) : sx_shift;
   assign sy_base  = fs ? (ste_pkg::MIRROR_Y - beat.y_word[ste_pkg::POS_W-1:0])
                        : beat.y_word[ste_pkg::POS_W-1:0];

   // Tile flips: own bits xor screen flip, or just screen flip
   assign fx = cfg.per_sprite_flip ? (beat.size_word[8] ^ fs) : fs;
   assign fy = cfg.per_sprite_flip ? (beat.size_word[9] ^ fs) : fs;

   // A flipped axis starts at the far tile
   assign x_span = {1'b0, width_m1, 4'b0000};
   assign y_span = {1'b0, height_m1, 4'b0000};

   always_comb begin
      sx_start = sx_base;
      sy_start = sy_base;
      if (cfg.per_sprite_flip && fx) begin
         sx_start = fs ? (sx_base - x_span) : (sx_base + x_span);
      end
      if (cfg.per_sprite_flip && fy) begin
         sy_start = fs ? (sy_base - y_span) : (sy_base + y_span);
      end
   end

   always_comb begin
      state_o             = '0;
      state_o.pending     = take_o;
      state_o.next_code   = beat.first_code;
      state_o.held_color  = beat.color_word;
      state_o.held_flips  = {fy, fx};
      // Step direction: the sprite's own flip bit, or screen flip alone
      state_o.step_dirs   = cfg.per_sprite_flip ? beat.size_word[9:8] : {fs, fs};
      state_o.cur_x       = sx_start;
      state_o.cur_y       = sy_start;
      state_o.row_start_x = sx_start;
      state_o.cols_left   = width_m1;
      state_o.row_width   = width_m1;
      state_o.rows_left   = height_m1;
   end

endmodule

`default_nettype wire

// ===== rtl/ste_tile_step.sv =====
// Tick advance: moves the walk state on by one tile in row-major order.
// Depends on ste_pkg.
`default_nettype none

module ste_tile_step (
   input  var ste_pkg::sprite_state_type state_i,
   output var ste_pkg::sprite_state_type state_o
);

   always_comb begin
      state_o           = state_i;
      state_o.next_code = state_i.next_code + 16'd1;
      if (state_i.cols_left != 4'd0) begin
         // Next column in this row
         state_o.cols_left = state_i.cols_left - 4'd1;
         state_o.cur_x     = state_i.step_dirs[0] ? (state_i.cur_x - ste_pkg::TILE_STEP)
                                                  : (state_i.cur_x + ste_pkg::TILE_STEP);
      end else begin
         // Wrap to the start of the next row
         state_o.rows_left = state_i.rows_left - 4'd1;
         state_o.cols_left = state_i.row_width;
         state_o.cur_x     = state_i.row_start_x;
         state_o.cur_y     = state_i.step_dirs[1] ? (state_i.cur_y - ste_pkg::TILE_STEP)
                                                  : (state_i.cur_y + ste_pkg::TILE_STEP);
      end
   end

endmodule

`default_nettype wire

// ===== rtl/sprite_tile_expander_top.sv =====
// Top level of the sprite tile expander: input register, sprite walk state,
// result register. Depends on ste_pkg, ste_load_setup and ste_tile_step.
//
// Usage:
//   req_* carries load beats (sprite entry plus pass priority) and tick
//   beats. A load that is enabled and matches the pass priority yields the
//   first tile on rsp_*; each tick then yields the next tile until the beat
//   flagged rsp_last_tile. Dropped loads and ticks with no sprite pending
//   yield nothing. A new load always replaces the sprite in progress.
//   csr_* writes flip_screen, x_shift and per_sprite_flip; write only while
//   the block is idle.
// Timing:
//   A request beat is registered in the input register, then worked
//   combinationally into the result register. One beat per cycle is
//   sustained while rsp_ready stays high; the walk state is updated once
//   per beat that moves on.
// Reset and stalls:
//   Reset clears configuration, the pending sprite and both valid flags.
//   While rsp_ready is low the result is held, one further beat waits in
//   the input register, and req_ready drops once both are full.
`default_nettype none

module sprite_tile_expander_top (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic [15:0] req_attr_word,
   input  logic [15:0] req_size_word,
   input  logic [15:0] req_first_code,
   input  logic [15:0] req_x_word,
   input  logic [15:0] req_y_word,
   input  logic [15:0] req_color_word,
   input  logic [1:0]  req_pass_priority,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_tile_code,
   output logic [15:0] rsp_tile_color,
   output logic        rsp_tile_flip_x,
   output logic        rsp_tile_flip_y,
   output logic signed [9:0] rsp_screen_x,
   output logic [8:0]  rsp_screen_y,
   output logic        rsp_last_tile,
   // configuration port
   input  logic                            csr_wr_en,
   input  logic [ste_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ste_pkg::CSR_DATA_W-1:0] csr_wdata
);

   ste_pkg::cfg_type          cfg_ff;
   ste_pkg::req_beat_type     beat_ff;
   logic                      beat_valid_ff;
   ste_pkg::sprite_state_type state_ff;
   ste_pkg::sprite_state_type state_in;
   ste_pkg::sprite_state_type load_state;
   ste_pkg::sprite_state_type step_state;
   ste_pkg::sprite_state_type sel_state;
   logic                      load_take;
   logic                      advance;
   logic                      has_result;
   logic                      is_last;
   logic [ste_pkg::POS_W-1:0] x_plus;

   logic                      rsp_valid_ff;
   logic [15:0]               code_ff;
   logic [15:0]               color_ff;
   logic [1:0]                flips_ff;
   logic [9:0]                sx_ff;
   logic [8:0]                sy_ff;
   logic                      last_ff;

   // Configuration writes; unknown indexes are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            ste_pkg::CSR_FLIP_SCREEN:     cfg_ff.flip_screen     <= csr_wdata[0];
            ste_pkg::CSR_X_SHIFT:         cfg_ff.x_shift         <= csr_wdata;
            ste_pkg::CSR_PER_SPRITE_FLIP: cfg_ff.per_sprite_flip <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Work stage moves on when the result register is free or draining
   assign advance   = beat_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !beat_valid_ff || advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         beat_valid_ff <= 1'b0;
      end else if (req_ready) begin
         beat_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         beat_ff.req_type      <= req_type;
         beat_ff.attr_word     <= req_attr_word;
         beat_ff.size_word     <= req_size_word;
         beat_ff.first_code    <= req_first_code;
         beat_ff.x_word        <= req_x_word;
         beat_ff.y_word        <= req_y_word;
         beat_ff.color_word    <= req_color_word;
         beat_ff.pass_priority <= req_pass_priority;
      end
   end

   ste_load_setup u_load (
      .beat    (beat_ff),
      .cfg     (cfg_ff),
      .state_o (load_state),
      .take_o  (load_take)
   );

   ste_tile_step u_step (
      .state_i (state_ff),
      .state_o (step_state)
   );

   // Choose the updated walk state and whether it yields a tile
   always_comb begin
      if (beat_ff.req_type == ste_pkg::REQ_LOAD) begin
         sel_state  = load_state;
         has_result = load_take;
      end else begin
         sel_state  = state_ff.pending ? step_state : state_ff;
         has_result = state_ff.pending;
      end
   end

   assign is_last = (sel_state.cols_left == 4'd0) && (sel_state.rows_left == 4'd0);
   assign x_plus  = sel_state.cur_x + ste_pkg::TILE_STEP;

   always_comb begin
      state_in         = sel_state;
      state_in.pending = sel_state.pending && !(has_result && is_last);
   end

   // Walk state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= has_result;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && has_result) begin
         code_ff  <= sel_state.next_code;
         color_ff <= sel_state.held_color;
         flips_ff <= sel_state.held_flips;
         // x wrapped into the range -16 to 495
         sx_ff    <= {1'b0, x_plus} - 10'd16;
         sy_ff    <= sel_state.cur_y;
         last_ff  <= is_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_tile_code   = code_ff;
   assign rsp_tile_color  = color_ff;
   assign rsp_tile_flip_x = flips_ff[0];
   assign rsp_tile_flip_y = flips_ff[1];
   assign rsp_screen_x    = sx_ff;
   assign rsp_screen_y    = sy_ff;
   assign rsp_last_tile   = last_ff;

endmodule

`default_nettype wire

// ===== tb/tb_sprite_tile_expander_top.sv =====
// Self-checking bench for sprite_tile_expander_top: directed table, then random sprite walks.
// Expected tiles come from an in-bench model of the walk; needs ste_pkg and the RTL only.
`default_nettype none

module tb_sprite_tile_expander_top;

   localparam int STALL_LIMIT = 2000;
   localparam int PROBE_COUNT = 23;
   localparam int PHASE_TILES = 180;

   // One tile placement as seen on the result channel
   typedef struct packed {
      logic [15:0] code;
      logic [15:0] color;
      logic        flip_x;
      logic        flip_y;
      logic [9:0]  screen_x;
      logic [8:0]  screen_y;
      logic        last;
   } tile_type;

   // Directed row: beat, and where pinned, the tile (or no tile) it must give
   typedef struct packed {
      ste_pkg::req_beat_type beat;
      logic                  pinned;
      logic                  has_tile;
      tile_type              tile;
   } probe_row_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_type = ste_pkg::REQ_LOAD;
   logic [15:0] req_attr_word = '0;
   logic [15:0] req_size_word = '0;
   logic [15:0] req_first_code = '0;
   logic [15:0] req_x_word = '0;
   logic [15:0] req_y_word = '0;
   logic [15:0] req_color_word = '0;
   logic [1:0]  req_pass_priority = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_tile_code;
   logic [15:0] rsp_tile_color;
   logic        rsp_tile_flip_x;
   logic        rsp_tile_flip_y;
   logic signed [9:0] rsp_screen_x;
   logic [8:0]  rsp_screen_y;
   logic        rsp_last_tile;
   logic                           csr_wr_en = 1'b0;
   logic [ste_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [ste_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   logic                      steady = 1'b0;
   int unsigned               quiet_cycles = 0;
   int unsigned               mismatches = 0;
   int unsigned               produced = 0;
   tile_type                  tiles_due[$];
   ste_pkg::sprite_state_type sprite_walk;
   ste_pkg::cfg_type          screen_cfg;

   sprite_tile_expander_top dut (
      .clock, .reset,
      .req_valid, .req_ready, .req_type, .req_attr_word, .req_size_word,
      .req_first_code, .req_x_word, .req_y_word, .req_color_word, .req_pass_priority,
      .rsp_valid, .rsp_ready, .rsp_tile_code, .rsp_tile_color, .rsp_tile_flip_x,
      .rsp_tile_flip_y, .rsp_screen_x, .rsp_screen_y, .rsp_last_tile,
      .csr_wr_en, .csr_index, .csr_wdata
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Fields: type, attr, size, code, x, y, colour, pass priority
   probe_row_type probes [PROBE_COUNT] = '{
      // tick with nothing pending
      '{'{ste_pkg::REQ_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd3},
        1'b1, 1'b0, '0},
      // disabled entry
      '{'{ste_pkg::REQ_LOAD, 16'hFFFE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 2'd3},
        1'b1, 1'b0, '0},
      // enabled but priority differs from the pass
      '{'{ste_pkg::REQ_LOAD, 16'h0041, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 2'd0},
        1'b1, 1'b0, '0},
      // single tile, all-ones fields, x just left of the wrap
      '{'{ste_pkg::REQ_LOAD, 16'h0001, 16'h0000, 16'hFFFF, 16'h01FF, 16'h01FF, 16'hFFFF, 2'd0},
        1'b1, 1'b1, '{16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 10'h3FF, 9'h1FF, 1'b1}},
      // tick once the sprite is done
      '{'{ste_pkg::REQ_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 2'd0},
        1'b1, 1'b0, '0},
      // 2x2 sprite, high position bits ignored, upper size bits ignored
      '{'{ste_pkg::REQ_LOAD, 16'hFFFF, 16'hFC11, 16'h1234, 16'hFE00, 16'hFE10, 16'hA5A5, 2'd3},
        1'b1, 1'b1, '{16'h1234, 16'hA5A5, 1'b0, 1'b0, 10'h000, 9'h010, 1'b0}},
      '{'{ste_pkg::REQ_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd3},
        1'b0, 1'b0, '0},
      '{'{ste_pkg::REQ_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 2'd1},
        1'b0, 1'b0, '0},
      '{'{ste_pkg::REQ_TICK, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 2'd2},
        1'b0, 1'b0, '0},
      '{'{ste_pkg::REQ_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd3},
        1'b1, 1'b0, '0},
      // 16x16 sprite wrapping x, code about to roll over
      '{'{ste_pkg::REQ_LOAD, 16'h00C1, 16'h00FF, 16'hFFFE, 16'h01F8, 16'h01F0, 16'h0000, 2'd3},
        1'b1, 1'b1, '{16'hFFFE, 16'h0000, 1'b0, 1'b0, 10'h3F8, 9'h1F0, 1'b0}},
      '{'{ste_pkg::REQ_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 2'd0},
        1'b0, 1'b0, '0},
      '{'{ste_pkg::REQ_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 2'd0},
        1'b0, 1'b0, '0},
      // new load abandons the big sprite
      '{'{ste_pkg::REQ_LOAD, 16'h0081, 16'h0010, 16'h8000, 16'h0100, 16'h0000, 16'h5A5A, 2'd2},
        1'b1, 1'b1, '{16'h8000, 16'h5A5A, 1'b0, 1'b0, 10'h100, 9'h000, 1'b0}},
      '{'{ste_pkg::REQ_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 2'd0},
        1'b0, 1'b0, '0},
      '{'{ste_pkg::REQ_LOAD, 16'h0001, 16'h0002, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 2'd0},
        1'b1, 1'b1, '{16'h0000, 16'h0000, 1'b0, 1'b0, 10'h000, 9'h000, 1'b0}},
      '{'{ste_pkg::REQ_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 2'd0},
        1'b0, 1'b0, '0},
      // dropped load cancels the pending sprite, so the tick gives nothing
      '{'{ste_pkg::REQ_LOAD, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 2'd0},
        1'b1, 1'b0, '0},
      '{'{ste_pkg::REQ_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 2'd0},
        1'b1, 1'b0, '0},
      // screen_x extremes: -16 and 495
      '{'{ste_pkg::REQ_LOAD, 16'h0001, 16'h0000, 16'h0F0F, 16'h01F0, 16'h0100, 16'h00FF, 2'd0},
        1'b1, 1'b1, '{16'h0F0F, 16'h00FF, 1'b0, 1'b0, 10'h3F0, 9'h100, 1'b1}},
      '{'{ste_pkg::REQ_LOAD, 16'h0001, 16'h0000, 16'h0000, 16'h01EF, 16'h0000, 16'h0000, 2'd0},
        1'b1, 1'b1, '{16'h0000, 16'h0000, 1'b0, 1'b0, 10'h1EF, 9'h000, 1'b1}},
      '{'{ste_pkg::REQ_LOAD, 16'h0001, 16'h0301, 16'h4444, 16'h0020, 16'h0030, 16'h1111, 2'd0},
        1'b0, 1'b0, '0},
      '{'{ste_pkg::REQ_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 2'd0},
        1'b0, 1'b0, '0}
   };

   // pos plus or minus 16*n, wrapping at 9 bits
   function automatic logic [8:0] tile_offset(input logic [8:0] pos, input logic [3:0] n,
                                              input logic back);
      logic [8:0] d;
      d = {1'b0, n, 4'b0000};
      if (back) d = 9'd0 - d;
      return pos + d;
   endfunction

   // Tile at the walk's current place; the final one ends the sprite
   function automatic tile_type current_tile();
      tile_type   t;
      logic [8:0] shifted;
      shifted    = sprite_walk.cur_x + 9'd16;
      t.code     = sprite_walk.next_code;
      t.color    = sprite_walk.held_color;
      t.flip_x   = sprite_walk.held_flips[0];
      t.flip_y   = sprite_walk.held_flips[1];
      t.screen_x = {1'b0, shifted} - 10'd16;
      t.screen_y = sprite_walk.cur_y;
      t.last     = (sprite_walk.cols_left == 4'd0) && (sprite_walk.rows_left == 4'd0);
      if (t.last) sprite_walk.pending = 1'b0;
      return t;
   endfunction

   // Advance the walk by one accepted beat; returns 1 where a tile results
   function automatic bit expand_beat(input ste_pkg::req_beat_type b, output tile_type t);
      logic       fs, fx, fy, xback, yback;
      logic [3:0] w, h;
      logic [8:0] sx, sy;
      t = '0;
      if (b.req_type == ste_pkg::REQ_LOAD) begin
         sprite_walk.pending = 1'b0;
         if (!b.attr_word[0] || b.attr_word[7:6] != b.pass_priority) return 0;
         fs = screen_cfg.flip_screen;
         w  = b.size_word[3:0];
         h  = b.size_word[7:4];
         sx = b.x_word[8:0] + {2'b00, screen_cfg.x_shift};
         sy = b.y_word[8:0];
         if (fs) begin
            sx = ste_pkg::MIRROR_X - sx;
            sy = ste_pkg::MIRROR_Y - sy;
         end
         if (screen_cfg.per_sprite_flip) begin
            // a flipped axis starts at its far end and walks back
            fx    = b.size_word[8] ^ fs;
            fy    = b.size_word[9] ^ fs;
            xback = fs ^ fx;
            yback = fs ^ fy;
            if (fy) sy = tile_offset(sy, h, fs);
            if (fx) sx = tile_offset(sx, w, fs);
         end else begin
            fx    = fs;
            fy    = fs;
            xback = fs;
            yback = fs;
         end
         sprite_walk.next_code   = b.first_code;
         sprite_walk.held_color  = b.color_word;
         sprite_walk.held_flips  = {fy, fx};
         sprite_walk.step_dirs   = {yback, xback};
         sprite_walk.row_start_x = sx;
         sprite_walk.cur_x       = sx;
         sprite_walk.cur_y       = sy;
         sprite_walk.row_width   = w;
         sprite_walk.cols_left   = w;
         sprite_walk.rows_left   = h;
         sprite_walk.pending     = 1'b1;
         t = current_tile();
         return 1;
      end
      if (!sprite_walk.pending) return 0;
      sprite_walk.next_code = sprite_walk.next_code + 16'd1;
      if (sprite_walk.cols_left != 4'd0) begin
         sprite_walk.cols_left = sprite_walk.cols_left - 4'd1;
         sprite_walk.cur_x = tile_offset(sprite_walk.cur_x, 4'd1, sprite_walk.step_dirs[0]);
      end else begin
         sprite_walk.rows_left = sprite_walk.rows_left - 4'd1;
         sprite_walk.cols_left = sprite_walk.row_width;
         sprite_walk.cur_x     = sprite_walk.row_start_x;
         sprite_walk.cur_y = tile_offset(sprite_walk.cur_y, 4'd1, sprite_walk.step_dirs[1]);
      end
      t = current_tile();
      return 1;
   endfunction

   task automatic note_error(input string msg);
      mismatches++;
      $display("ERROR at %0t: %s", $time, msg);
   endtask

   function automatic ste_pkg::req_beat_type random_beat();
      ste_pkg::req_beat_type b;
      b.req_type      = 1'($urandom_range(0, 1));
      b.attr_word     = 16'($urandom);
      b.size_word     = 16'($urandom);
      b.first_code    = 16'($urandom);
      b.x_word        = 16'($urandom);
      b.y_word        = 16'($urandom);
      b.color_word    = 16'($urandom);
      b.pass_priority = 2'($urandom_range(0, 3));
      return b;
   endfunction

   // Present one beat, with an occasional gap first outside the steady stretch, and wait for the handshake
   task automatic drive_beat(input ste_pkg::req_beat_type b);
      while (!steady && $urandom_range(0, 99) < 9) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_type          <= b.req_type;
      req_attr_word     <= b.attr_word;
      req_size_word     <= b.size_word;
      req_first_code    <= b.first_code;
      req_x_word        <= b.x_word;
      req_y_word        <= b.y_word;
      req_color_word    <= b.color_word;
      req_pass_priority <= b.pass_priority;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic issue(input ste_pkg::req_beat_type b);
      tile_type t;
      drive_beat(b);
      if (expand_beat(b, t)) begin
         tiles_due.push_back(t);
         produced++;
      end
   endtask

   // Drain every expected tile, then give a dropped beat time to leave the pipe
   task automatic settle();
      req_valid <= 1'b0;
      while (tiles_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_screen(input logic fs, input logic [6:0] xs, input logic psf);
      csr_wr_en <= 1'b1;
      csr_index <= ste_pkg::CSR_FLIP_SCREEN;
      csr_wdata <= {6'd0, fs};
      @(posedge clock);
      csr_index <= ste_pkg::CSR_X_SHIFT;
      csr_wdata <= xs;
      @(posedge clock);
      csr_index <= ste_pkg::CSR_PER_SPRITE_FLIP;
      csr_wdata <= {6'd0, psf};
      @(posedge clock);
      csr_wr_en <= 1'b0;
      screen_cfg.flip_screen     = fs;
      screen_cfg.x_shift         = xs;
      screen_cfg.per_sprite_flip = psf;
   endtask

   // Mostly whole sprites walked to the end; some cut short, some overrun, some junk
   task automatic run_sprites(input int unsigned goal);
      ste_pkg::req_beat_type b;
      int unsigned           w, h, tiles, ticks, pick, start;
      start = produced;
      while (produced - start < goal) begin
         b = random_beat();
         b.req_type = ste_pkg::REQ_LOAD;
         if ($urandom_range(0, 99) < 10) begin
            issue(b);
            ticks = $urandom_range(0, 3);
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 85) begin
               w = $urandom_range(0, 3);
               h = $urandom_range(0, 3);
            end else if (pick < 97) begin
               w = $urandom_range(0, 15);
               h = $urandom_range(0, 1);
               if ($urandom_range(0, 1)) begin
                  h = w;
                  w = $urandom_range(0, 1);
               end
            end else begin
               w = $urandom_range(0, 15);
               h = $urandom_range(0, 15);
            end
            b.attr_word[0]    = 1'b1;
            b.attr_word[7:6]  = b.pass_priority;
            b.size_word[3:0]  = 4'(w);
            b.size_word[7:4]  = 4'(h);
            issue(b);
            tiles = (w + 1) * (h + 1);
            pick  = $urandom_range(0, 99);
            if (pick < 12) ticks = $urandom_range(0, tiles - 1);
            else if (pick < 22) ticks = tiles - 1 + $urandom_range(1, 3);
            else ticks = tiles - 1;
         end
         repeat (ticks) begin
            b = random_beat();
            b.req_type = ste_pkg::REQ_TICK;
            issue(b);
         end
      end
   endtask

   // Result side stalls at random unless in the steady stretch
   always @(posedge clock) rsp_ready <= steady || ($urandom_range(0, 99) >= 9);

   // Compare each result beat with the oldest expected tile
   always @(posedge clock) begin
      tile_type seen, want;
      if (!reset && rsp_valid && rsp_ready) begin
         seen = '{rsp_tile_code, rsp_tile_color, rsp_tile_flip_x, rsp_tile_flip_y,
                  rsp_screen_x, rsp_screen_y, rsp_last_tile};
         if (tiles_due.size() == 0) begin
            note_error($sformatf("tile %h with nothing expected", seen.code));
         end else begin
            want = tiles_due.pop_front();
            if (seen.code !== want.code)
               note_error($sformatf("tile_code %h, want %h", seen.code, want.code));
            if (seen.color !== want.color)
               note_error($sformatf("tile_color %h, want %h", seen.color, want.color));
            if (seen.flip_x !== want.flip_x)
               note_error($sformatf("tile_flip_x %b, want %b", seen.flip_x, want.flip_x));
            if (seen.flip_y !== want.flip_y)
               note_error($sformatf("tile_flip_y %b, want %b", seen.flip_y, want.flip_y));
            if (seen.screen_x !== want.screen_x)
               note_error($sformatf("screen_x %h, want %h", seen.screen_x, want.screen_x));
            if (seen.screen_y !== want.screen_y)
               note_error($sformatf("screen_y %h, want %h", seen.screen_y, want.screen_y));
            if (seen.last !== want.last)
               note_error($sformatf("last_tile %b, want %b", seen.last, want.last));
         end
      end
   end

   // Watchdog: too long without any beat on either channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      tile_type t;
      bit       made;
      sprite_walk = '0;
      screen_cfg  = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      set_screen(1'b0, 7'd0, 1'b0);

      // directed table
      for (int i = 0; i < PROBE_COUNT; i++) begin
         drive_beat(probes[i].beat);
         made = expand_beat(probes[i].beat, t);
         if (probes[i].pinned) begin
            if (probes[i].has_tile) tiles_due.push_back(probes[i].tile);
         end else if (made) begin
            tiles_due.push_back(t);
         end
      end
      settle();

      // random phases over the register settings
      set_screen(1'b0, 7'd0, 1'b1);
      run_sprites(PHASE_TILES);
      settle();
      steady <= 1'b1;
      set_screen(1'b1, 7'd64, 1'b1);
      run_sprites(PHASE_TILES);
      settle();
      steady <= 1'b0;
      set_screen(1'b0, 7'd127, 1'b1);
      run_sprites(PHASE_TILES);
      settle();
      set_screen(1'b1, 7'd0, 1'b0);
      run_sprites(PHASE_TILES);
      settle();
      set_screen(1'b0, 7'd64, 1'b0);
      run_sprites(PHASE_TILES);
      settle();
      set_screen(1'b1, 7'd127, 1'b1);
      run_sprites(PHASE_TILES);
      settle();

      if (tiles_due.size() != 0)
         note_error($sformatf("%0d tiles never arrived", tiles_due.size()));
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/ste_pkg.sv
rtl/ste_load_setup.sv
rtl/ste_tile_step.sv
rtl/sprite_tile_expander_top.sv
tb/tb_sprite_tile_expander_top.sv
